/* rtl/multi_job_byte_fifo_unit_macros.svh */
// Assertion macros for the checker file of the job byte FIFO.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef MULTI_JOB_BYTE_FIFO_UNIT_MACROS_SVH
`define MULTI_JOB_BYTE_FIFO_UNIT_MACROS_SVH

// Same-cycle implication.
`define MJBF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mjbf check failed");

// Next-cycle implication.
`define MJBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mjbf check failed");

`endif

/* rtl/mjbf_pkg.sv */
// Shared constants and types of the job byte FIFO.
// No dependencies.
package mjbf_pkg;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int JOB_SLOTS_DEF  = 8;
  localparam int BURST_MAX_DEF  = 16;
  localparam int BURST_RESET    = 4;
  localparam int RESERVE_RESET  = 140;
  localparam int CMD_W          = 3;
  localparam int BYTE_W         = 8;
  localparam int BURST_FIELD_W  = 5;
  localparam int RESERVE_W      = 11;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN, CMD_FEED, CMD_END, CMD_CANCEL,
    CMD_CLEAR, CMD_POLL, CMD_TIMEOUT, CMD_CLR_ERR
  } cmd_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RESP, ST_RD, ST_WAIT} state_t;

  typedef enum logic {REG_BURST, REG_RESERVE} reg_idx_t;

endpackage

/* rtl/multi_job_byte_fifo_unit.sv */
// Job byte FIFO top level: job queue, ring control, poll sequencer, APB registers.
// Depends on mjbf_pkg and mjbf_ring.
//
//  channel | direction | handshake          | contents
//  in_     | to block  | in_valid/in_ready  | cmd, data_byte, run_enable
//  out_    | from block| out_valid/out_ready| accepted, byte, last, status
//  cfg_    | to block  | APB, pready high   | burst_length, space_reserve
//
// A command is accepted, then the result word is registered once the output is free.
// A poll reads the ring once per emitted byte: a read state presents the address,
// then a wait state loads the data into the output register.
// Reset is synchronous; the ring contents are not cleared.
// A stalled output holds the sequencer; in_ready is low until the last word loads.
module multi_job_byte_fifo_unit #(
  parameter int RING_DEPTH = mjbf_pkg::RING_DEPTH_DEF,
  parameter int JOB_SLOTS  = mjbf_pkg::JOB_SLOTS_DEF,
  parameter int BURST_MAX  = mjbf_pkg::BURST_MAX_DEF,
  localparam int AW  = $clog2(RING_DEPTH),
  localparam int CW  = $clog2(RING_DEPTH + 1),
  localparam int SW  = $clog2(JOB_SLOTS),
  localparam int TW  = $clog2(JOB_SLOTS + 1),
  localparam int BW  = $clog2(BURST_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mjbf_pkg::CMD_W-1:0]    in_cmd,
  input  logic [mjbf_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          in_run_enable,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic                          out_out_valid,
  output logic [mjbf_pkg::BYTE_W-1:0]   out_out_byte,
  output logic                          out_last,
  output logic [TW-1:0]                 out_jobs_queued,
  output logic [CW-1:0]                 out_bytes_buffered,
  output logic                          out_has_room,
  output logic                          out_printing,
  output logic                          out_error_flag,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mjbf_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [mjbf_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [mjbf_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int SW1    = SW + 1;
  localparam int AW1    = AW + 1;
  localparam int CMP_W  = ((CW > mjbf_pkg::RESERVE_W) ? CW : mjbf_pkg::RESERVE_W) + 1;
  localparam int BURST_RST = (mjbf_pkg::BURST_RESET > BURST_MAX) ? BURST_MAX
                                                                  : mjbf_pkg::BURST_RESET;

  // configuration
  logic [BW-1:0]                    burst_r;
  logic [mjbf_pkg::RESERVE_W-1:0]   reserve_r;
  logic                             cfg_we;
  logic [mjbf_pkg::BURST_FIELD_W-1:0] burst_wv;
  mjbf_pkg::reg_idx_t               cfg_idx;

  // queue and ring state
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [SW-1:0] first_r, first_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          fault_r, fault_nxt;
  logic          active_r, active_nxt;
  logic [CW-1:0] jbc_r  [JOB_SLOTS];
  logic [CW-1:0] jbc_nxt[JOB_SLOTS];
  logic          open_r [JOB_SLOTS];
  logic          open_nxt[JOB_SLOTS];
  logic          disc_r [JOB_SLOTS];
  logic          disc_nxt[JOB_SLOTS];
  logic          acc_r, acc_c;
  logic [BW-1:0] n_r;

  mjbf_pkg::state_t state_r, state_nxt;
  mjbf_pkg::cmd_t   cmd;

  logic cmd_go, take, load, out_free, poll_emit, more;

  logic [SW1-1:0] tsum, nsum;
  logic [SW-1:0]  tail, nslot, head_next;
  logic [AW1-1:0] wsum, dsum;
  logic [AW-1:0]  wr_addr, drain_rp, rp_inc;
  logic [CMP_W-1:0] free_c;
  logic           room;
  logic           mem_we;
  logic [mjbf_pkg::BYTE_W-1:0] rd_data;

  assign cmd = mjbf_pkg::cmd_t'(in_cmd);

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;
  assign burst_wv   = cfg_pwdata[mjbf_pkg::BURST_FIELD_W-1:0];
  assign cfg_idx    = mjbf_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r   <= BW'(BURST_RST);
      reserve_r <= mjbf_pkg::RESERVE_W'(mjbf_pkg::RESERVE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mjbf_pkg::REG_BURST: begin
          if (burst_wv == '0) begin
            burst_r <= BW'(1);
          end else if (int'(burst_wv) > BURST_MAX) begin
            burst_r <= BW'(BURST_MAX);
          end else begin
            burst_r <= BW'(burst_wv);
          end
        end
        mjbf_pkg::REG_RESERVE: reserve_r <= cfg_pwdata[mjbf_pkg::RESERVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mjbf_pkg::REG_BURST:   cfg_prdata = mjbf_pkg::DATA_W'(burst_r);
      mjbf_pkg::REG_RESERVE: cfg_prdata = mjbf_pkg::DATA_W'(reserve_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // ---------------- derived indexes ----------------
  always_comb begin
    tsum = SW1'(first_r) + SW1'(total_r) - SW1'(1);
    if (tsum >= SW1'(JOB_SLOTS)) tsum = tsum - SW1'(JOB_SLOTS);
    tail = tsum[SW-1:0];
    nsum = SW1'(first_r) + SW1'(total_r);
    if (nsum >= SW1'(JOB_SLOTS)) nsum = nsum - SW1'(JOB_SLOTS);
    nslot = nsum[SW-1:0];
    head_next = (first_r == SW'(JOB_SLOTS - 1)) ? '0 : first_r + SW'(1);
    wsum = AW1'(rp_r) + AW1'(fill_r);
    if (wsum >= AW1'(RING_DEPTH)) wsum = wsum - AW1'(RING_DEPTH);
    wr_addr = wsum[AW-1:0];
    dsum = AW1'(rp_r) + AW1'(jbc_r[first_r]);
    if (dsum >= AW1'(RING_DEPTH)) dsum = dsum - AW1'(RING_DEPTH);
    drain_rp = dsum[AW-1:0];
    rp_inc = (rp_r == AW'(RING_DEPTH - 1)) ? '0 : rp_r + AW'(1);
  end

  assign free_c = CMP_W'(RING_DEPTH) - CMP_W'(fill_r);
  assign room   = ((total_r != '0) && disc_r[tail]) || (free_c >= CMP_W'(reserve_r));
  assign more   = (n_r != '0) && (total_r != '0) && !disc_r[first_r] &&
                  (jbc_r[first_r] != '0) && (fill_r != '0);

  // ---------------- command datapath ----------------
  always_comb begin
    rp_nxt     = rp_r;
    fill_nxt   = fill_r;
    first_nxt  = first_r;
    total_nxt  = total_r;
    fault_nxt  = fault_r;
    active_nxt = active_r;
    jbc_nxt    = jbc_r;
    open_nxt   = open_r;
    disc_nxt   = disc_r;
    acc_c      = 1'b0;
    mem_we     = 1'b0;
    poll_emit  = 1'b0;
    if (cmd_go) begin
      unique case (cmd)
        mjbf_pkg::CMD_BEGIN: begin
          if (total_r < TW'(JOB_SLOTS)) begin
            jbc_nxt[nslot]  = '0;
            open_nxt[nslot] = 1'b1;
            disc_nxt[nslot] = 1'b0;
            total_nxt       = total_r + TW'(1);
            acc_c           = 1'b1;
          end
        end
        mjbf_pkg::CMD_FEED: begin
          if ((total_r != '0) && open_r[tail]) begin
            if (disc_r[tail]) begin
              acc_c = 1'b1;
            end else if (fill_r < CW'(RING_DEPTH)) begin
              mem_we        = 1'b1;
              fill_nxt      = fill_r + CW'(1);
              jbc_nxt[tail] = jbc_r[tail] + CW'(1);
              acc_c         = 1'b1;
            end
          end
        end
        mjbf_pkg::CMD_END: begin
          if ((total_r != '0) && open_r[tail]) begin
            open_nxt[tail] = 1'b0;
            if (((tail == first_r) || !open_r[first_r]) && (jbc_r[first_r] == '0)) begin
              first_nxt = head_next;
              total_nxt = total_r - TW'(1);
            end
          end
        end
        mjbf_pkg::CMD_CANCEL, mjbf_pkg::CMD_TIMEOUT: begin
          if (cmd == mjbf_pkg::CMD_TIMEOUT) begin
            fault_nxt  = 1'b1;
            active_nxt = 1'b0;
          end
          if (total_r != '0) begin
            disc_nxt[first_r] = 1'b1;
            rp_nxt            = drain_rp;
            fill_nxt          = fill_r - jbc_r[first_r];
            jbc_nxt[first_r]  = '0;
            if (!open_r[first_r]) begin
              first_nxt = head_next;
              total_nxt = total_r - TW'(1);
            end
          end
        end
        mjbf_pkg::CMD_CLEAR: begin
          rp_nxt     = '0;
          fill_nxt   = '0;
          first_nxt  = '0;
          total_nxt  = '0;
          active_nxt = 1'b0;
        end
        mjbf_pkg::CMD_POLL: begin
          if (!fault_r) begin
            priority if (!in_run_enable || (total_r == '0)) begin
              active_nxt = 1'b0;
            end else if (disc_r[first_r]) begin
              rp_nxt           = drain_rp;
              fill_nxt         = fill_r - jbc_r[first_r];
              jbc_nxt[first_r] = '0;
              if (!open_r[first_r]) begin
                first_nxt = head_next;
                total_nxt = total_r - TW'(1);
              end
            end else if (jbc_r[first_r] == '0) begin
              active_nxt = 1'b0;
              if (!open_r[first_r]) begin
                first_nxt = head_next;
                total_nxt = total_r - TW'(1);
              end
            end else begin
              active_nxt = 1'b1;
              poll_emit  = 1'b1;
            end
          end
        end
        mjbf_pkg::CMD_CLR_ERR: fault_nxt = 1'b0;
        default: ;
      endcase
    end else if (take) begin
      // one byte leaves the head job; retire it if closed and now empty
      rp_nxt           = rp_inc;
      fill_nxt         = fill_r - CW'(1);
      jbc_nxt[first_r] = jbc_r[first_r] - CW'(1);
      if (!open_r[first_r] && (jbc_r[first_r] == CW'(1))) begin
        first_nxt = head_next;
        total_nxt = total_r - TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r     <= '0;
      fill_r   <= '0;
      first_r  <= '0;
      total_r  <= '0;
      fault_r  <= 1'b0;
      active_r <= 1'b0;
      state_r  <= mjbf_pkg::ST_IDLE;
      n_r      <= '0;
    end else begin
      rp_r     <= rp_nxt;
      fill_r   <= fill_nxt;
      first_r  <= first_nxt;
      total_r  <= total_nxt;
      fault_r  <= fault_nxt;
      active_r <= active_nxt;
      state_r  <= state_nxt;
      if (poll_emit) begin
        n_r <= burst_r;
      end else if (take) begin
        n_r <= n_r - BW'(1);
      end
    end
  end

  // descriptors: only slots inside the queue are ever read
  always_ff @(posedge clk) begin
    jbc_r  <= jbc_nxt;
    open_r <= open_nxt;
    disc_r <= disc_nxt;
    if (cmd_go) begin
      acc_r <= acc_c;
    end
  end

  mjbf_ring #(.DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data (in_data_byte),
    .rd_en   (take),
    .rd_addr (rp_r),
    .rd_data (rd_data)
  );

  // ---------------- sequencer ----------------
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mjbf_pkg::ST_IDLE: if (cmd_go) state_nxt = poll_emit ? mjbf_pkg::ST_RD : mjbf_pkg::ST_RESP;
      mjbf_pkg::ST_RESP: if (out_free) state_nxt = mjbf_pkg::ST_IDLE;
      mjbf_pkg::ST_RD:   state_nxt = mjbf_pkg::ST_WAIT;
      mjbf_pkg::ST_WAIT: if (out_free) state_nxt = more ? mjbf_pkg::ST_RD : mjbf_pkg::ST_IDLE;
      default:           state_nxt = mjbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == mjbf_pkg::ST_IDLE);
    cmd_go   = in_valid && in_ready;
    take     = (state_r == mjbf_pkg::ST_RD);
    load     = ((state_r == mjbf_pkg::ST_RESP) || (state_r == mjbf_pkg::ST_WAIT)) && out_free;
  end

  // ---------------- output word register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_accepted       <= (state_r == mjbf_pkg::ST_RESP) ? acc_r : 1'b0;
      out_out_valid      <= (state_r == mjbf_pkg::ST_WAIT);
      out_out_byte       <= (state_r == mjbf_pkg::ST_WAIT) ? rd_data : '0;
      out_last           <= (state_r == mjbf_pkg::ST_RESP) ? 1'b1 : !more;
      out_jobs_queued    <= total_r;
      out_bytes_buffered <= fill_r;
      out_has_room       <= room;
      out_printing       <= active_r;
      out_error_flag     <= fault_r;
    end
  end

endmodule

/* rtl/mjbf_ring.sv */
// Byte ring storage: one write port, one read port with registered data.
// Depends on mjbf_pkg.
module mjbf_ring #(
  parameter int DEPTH = mjbf_pkg::RING_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [mjbf_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [mjbf_pkg::BYTE_W-1:0] rd_data
);

  logic [mjbf_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/mjbf_chk.sv */
// Port-level checker for the job byte FIFO, bound to the top level.
// Depends on multi_job_byte_fifo_unit_macros.svh.
`include "multi_job_byte_fifo_unit_macros.svh"

module mjbf_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_accepted,
  input logic       out_out_valid,
  input logic [7:0] out_out_byte,
  input logic       out_last
);

  `MJBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `MJBF_ASSERT_NEXT(a_byte_hold, out_valid && !out_ready, $stable(out_out_byte))
  // a word without a byte is always the only word of its command
  `MJBF_ASSERT_NOW(a_nobyte_last, out_valid && !out_out_valid, out_last)
  `MJBF_ASSERT_NOW(a_acc_nobyte, out_valid && out_accepted, !out_out_valid)

endmodule

bind multi_job_byte_fifo_unit mjbf_chk u_mjbf_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_accepted  (out_accepted),
  .out_out_valid (out_out_valid),
  .out_out_byte  (out_out_byte),
  .out_last      (out_last)
);
